@@ hw/rtl/bcef_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcef_pkg: shared types, codes and helpers for the button change queue
// Holds the command and response item layouts, the stored entry layout,
// the command and status codes, and the GPIO to button word remapping.
// ----------------------------------------------------------------------------
package bcef_pkg;

    // Default number of queue slots; one slot always stays unused.
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int BTN_W   = 6;
    localparam int TIME_W  = 63;
    localparam int DROP_W  = 32;
    localparam int FILL_W  = 4;

    // Command codes.
    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Poll status codes.
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_QUEUED  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    // Command item.
    typedef struct packed {
        logic              command;
        logic [7:0]        gpio_low;
        logic [7:0]        gpio_high;
        logic [TIME_W-1:0] timestamp;
    } cmd_t;

    // Response item.
    typedef struct packed {
        logic [1:0]        poll_status;
        logic              read_ok;
        logic [BTN_W-1:0]  sample_buttons;
        logic [TIME_W-1:0] sample_time;
        logic [DROP_W-1:0] drop_count;
        logic [FILL_W-1:0] fill_level;
    } rsp_t;

    // One stored queue entry.
    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Invert the active-low GPIO bytes and gather the six button bits.
    function automatic logic [BTN_W-1:0] remap_buttons(
        input logic [7:0] lo,
        input logic [7:0] hi
    );
        logic [7:0] nl;
        logic [7:0] nh;
        nl = ~lo;
        nh = ~hi;
        return {nl[6], nh[6], nl[4:1]};
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bcef_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcef_mem: sample storage
// Simple dual-port synchronous memory with one write port and one read
// port; read data is registered and appears in the cycle after the read request.
// ----------------------------------------------------------------------------
module bcef_mem #(
    parameter int QUEUE_DEPTH = bcef_pkg::QUEUE_DEPTH_DEF,
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [PW-1:0]   waddr,
    input  wire bcef_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [PW-1:0]   raddr,
    output bcef_pkg::entry_t     rdata
);

    bcef_pkg::entry_t mem [QUEUE_DEPTH];
    bcef_pkg::entry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/bcef_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcef_ctrl: queue pointers, change detection and response register
// Remaps each poll into a button word, pushes changed words into the
// sample memory, pops samples on reads and builds the response item.
// ----------------------------------------------------------------------------
module bcef_ctrl #(
    parameter int QUEUE_DEPTH = bcef_pkg::QUEUE_DEPTH_DEF,
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire bcef_pkg::cmd_t   cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output bcef_pkg::rsp_t        rsp,
    output logic                  mem_we,
    output logic [PW-1:0]         mem_waddr,
    output bcef_pkg::entry_t      mem_wdata,
    output logic                  mem_re,
    output logic [PW-1:0]         mem_raddr,
    input  wire bcef_pkg::entry_t mem_rdata
);

    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_MOD = PW'(QUEUE_DEPTH);
    localparam int            XW        = (PW > bcef_pkg::FILL_W) ? PW : bcef_pkg::FILL_W;

    logic [PW-1:0]               rp_reg, rp_next;
    logic [PW-1:0]               wp_reg, wp_next;
    logic [bcef_pkg::BTN_W-1:0]  last_reg, last_next;
    logic [bcef_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic                        pend_reg, pend_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    bcef_pkg::rsp_t              rsp_reg, rsp_next;

    logic                        accept;
    logic [bcef_pkg::BTN_W-1:0]  btn;
    logic [PW-1:0]               wp_inc;
    logic [PW-1:0]               rp_inc;
    logic                        full;
    logic                        empty;
    logic [PW-1:0]               fill;
    logic [XW-1:0]               fill_x;

    // Ring increment with wrap at the last slot.
    assign wp_inc = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == LAST_SLOT) ? '0 : rp_reg + 1'b1;

    assign btn    = bcef_pkg::remap_buttons(cmd.gpio_low, cmd.gpio_high);
    assign full   = (wp_inc == rp_reg);
    assign empty  = (wp_reg == rp_reg);

    // Input is taken unless a pop waits on memory or the response is stuck.
    assign cmd_ready = !pend_reg && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;

    // Samples waiting after this item, modulo the queue depth.
    assign fill   = (wp_next - rp_next) + ((wp_next < rp_next) ? DEPTH_MOD : '0);
    assign fill_x = XW'(fill);

    // Memory write and read requests.
    assign mem_waddr         = wp_reg;
    assign mem_wdata.buttons = btn;
    assign mem_wdata.stamp   = cmd.timestamp;
    assign mem_raddr         = rp_reg;

    // Next-state logic.
    always_comb
    begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        last_next      = last_reg;
        drop_next      = drop_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (accept)
        begin
            rsp_next                = '0;
            rsp_next.poll_status    = bcef_pkg::STATUS_NONE;
            rsp_valid_next          = 1'b1;
            if (cmd.command == bcef_pkg::CMD_POLL)
            begin
                if (btn != last_reg)
                begin
                    if (full)
                    begin
                        if (drop_reg != '1)
                        begin
                            drop_next = drop_reg + 1'b1;
                        end
                        rsp_next.poll_status = bcef_pkg::STATUS_DROPPED;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        wp_next              = wp_inc;
                        last_next            = btn;
                        rsp_next.poll_status = bcef_pkg::STATUS_QUEUED;
                    end
                end
            end
            else if (!empty)
            begin
                // Pop: the sample arrives from memory in the next cycle.
                mem_re           = 1'b1;
                rp_next          = rp_inc;
                pend_next        = 1'b1;
                rsp_valid_next   = 1'b0;
                rsp_next.read_ok = 1'b1;
            end
            rsp_next.drop_count = drop_next;
            rsp_next.fill_level = fill_x[bcef_pkg::FILL_W-1:0];
        end
        else if (pend_reg)
        begin
            rsp_next.sample_buttons = mem_rdata.buttons;
            rsp_next.sample_time    = mem_rdata.stamp;
            rsp_valid_next          = 1'b1;
            pend_next               = 1'b0;
        end
        else if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            last_reg      <= '0;
            drop_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            last_reg      <= last_next;
            drop_reg      <= drop_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

@@ hw/rtl/button_change_event_fifo_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_change_event_fifo_top: button change event queue
// Polls remap GPIO into a button word and queue it with its timestamp when
// it changes; reads pop the oldest queued sample.
// ----------------------------------------------------------------------------
// Each command item yields exactly one response item. Polls and reads of an
// empty queue are answered in the cycle after they are taken, and a new item
// is accepted every cycle while the response side keeps up. A read that pops
// a sample waits on the registered read port of the sample memory, and no new
// item is taken while that read is in flight. The queue holds QUEUE_DEPTH - 1
// samples; when full, a changed word is counted as a drop and retried on the
// next poll. No clearing pass is needed after reset.
module button_change_event_fifo_top #(
    parameter int QUEUE_DEPTH = bcef_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire bcef_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output bcef_pkg::rsp_t      rsp
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic             mem_we;
    logic [PW-1:0]    mem_waddr;
    bcef_pkg::entry_t mem_wdata;
    logic             mem_re;
    logic [PW-1:0]    mem_raddr;
    bcef_pkg::entry_t mem_rdata;

    // Pointer, change detection and response logic.
    bcef_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Sample storage.
    bcef_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

@@ bench/button_change_event_fifo_top_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_change_event_fifo_top_tb: self-checking bench for the button queue
// Drives poll and read items through the valid/ready command channel and
// checks every response against a cycle-free shadow of the queue: button
// remapping, change detection, drops when full, pops and the fill level.
// ----------------------------------------------------------------------------
module button_change_event_fifo_top_tb;

    localparam int DEPTH      = 16;
    localparam int RUN_LIMIT  = 2_000_000;
    localparam int DRAIN_WAIT = 4000;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_ready;
    bcef_pkg::cmd_t cmd;
    logic           rsp_valid;
    logic           rsp_ready;
    bcef_pkg::rsp_t rsp;

    // Shadow copy of the queue state.
    logic [bcef_pkg::BTN_W-1:0]  shadow_buttons [DEPTH];
    logic [bcef_pkg::TIME_W-1:0] shadow_stamps  [DEPTH];
    int                          shadow_rd    = 0;
    int                          shadow_wr    = 0;
    logic [bcef_pkg::BTN_W-1:0]  shadow_last  = '0;
    logic [bcef_pkg::DROP_W-1:0] shadow_drops = '0;

    // Responses predicted for accepted items, oldest first.
    bcef_pkg::rsp_t pending_responses [$];

    int errors       = 0;
    int cmd_idle_pct = 38;
    int rsp_idle_pct = 38;
    logic [bcef_pkg::BTN_W-1:0] stim_word = '0;

    button_change_event_fifo_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // Clock with a period of 4.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Response side stalls at random.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    // Apply one item to the shadow queue and return the response it causes.
    function automatic bcef_pkg::rsp_t button_queue_response(input bcef_pkg::cmd_t item);
        bcef_pkg::rsp_t             r;
        logic [7:0]                 nl;
        logic [7:0]                 nh;
        logic [bcef_pkg::BTN_W-1:0] word;
        int                         next_wr;
        r = '0;
        if (item.command == bcef_pkg::CMD_POLL)
        begin
            nl = ~item.gpio_low;
            nh = ~item.gpio_high;
            word[0] = nl[1];
            word[1] = nl[2];
            word[2] = nl[3];
            word[3] = nl[4];
            word[4] = nh[6];
            word[5] = nl[6];
            if (word != shadow_last)
            begin
                next_wr = (shadow_wr + 1) % DEPTH;
                if (next_wr == shadow_rd)
                begin
                    // Full: count the drop and keep the old reference word.
                    if (shadow_drops != {bcef_pkg::DROP_W{1'b1}})
                        shadow_drops = shadow_drops + 1'b1;
                    r.poll_status = bcef_pkg::STATUS_DROPPED;
                end
                else
                begin
                    shadow_buttons[shadow_wr] = word;
                    shadow_stamps[shadow_wr]  = item.timestamp;
                    shadow_wr   = next_wr;
                    shadow_last = word;
                    r.poll_status = bcef_pkg::STATUS_QUEUED;
                end
            end
        end
        else if (shadow_rd != shadow_wr)
        begin
            r.read_ok        = 1'b1;
            r.sample_buttons = shadow_buttons[shadow_rd];
            r.sample_time    = shadow_stamps[shadow_rd];
            shadow_rd = (shadow_rd + 1) % DEPTH;
        end
        r.drop_count = shadow_drops;
        r.fill_level = bcef_pkg::FILL_W'((shadow_wr + DEPTH - shadow_rd) % DEPTH);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Predict on every accepted item, then check every accepted response.
    always @(posedge clk)
    begin
        bcef_pkg::rsp_t want;
        if (rst_n && cmd_valid && cmd_ready)
            pending_responses.push_back(button_queue_response(cmd));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response item arrived with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("poll_status", 64'(want.poll_status), 64'(rsp.poll_status));
                check_field("read_ok", 64'(want.read_ok), 64'(rsp.read_ok));
                check_field("sample_buttons", 64'(want.sample_buttons),
                            64'(rsp.sample_buttons));
                check_field("sample_time", 64'(want.sample_time), 64'(rsp.sample_time));
                check_field("drop_count", 64'(want.drop_count), 64'(rsp.drop_count));
                check_field("fill_level", 64'(want.fill_level), 64'(rsp.fill_level));
            end
        end
    end

    // Offer one item, with a random gap first, and wait until it is taken.
    task automatic send_item(input bcef_pkg::cmd_t item);
        while ($urandom_range(0, 99) < cmd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // Poll whose GPIO bytes encode the given word; unused bits are random.
    task automatic send_poll(input logic [bcef_pkg::BTN_W-1:0] word);
        bcef_pkg::cmd_t item;
        logic [7:0]     lo;
        logic [7:0]     hi;
        lo = 8'($urandom);
        hi = 8'($urandom);
        lo[4:1] = ~word[3:0];
        lo[6]   = ~word[5];
        hi[6]   = ~word[4];
        item.command   = bcef_pkg::CMD_POLL;
        item.gpio_low  = lo;
        item.gpio_high = hi;
        item.timestamp = bcef_pkg::TIME_W'({$urandom, $urandom});
        stim_word = word;
        send_item(item);
    endtask

    // Read with junk in the fields that a read ignores.
    task automatic send_read();
        bcef_pkg::cmd_t item;
        item.command   = bcef_pkg::CMD_READ;
        item.gpio_low  = 8'($urandom);
        item.gpio_high = 8'($urandom);
        item.timestamp = bcef_pkg::TIME_W'({$urandom, $urandom});
        send_item(item);
    endtask

    // Extreme field values, empty reads and unchanged polls.
    task automatic test_extremes();
        bcef_pkg::cmd_t item;
        item = '{command: bcef_pkg::CMD_READ, gpio_low: 8'hFF, gpio_high: 8'hFF,
                 timestamp: {bcef_pkg::TIME_W{1'b1}}};
        send_item(item);
        item = '{command: bcef_pkg::CMD_POLL, gpio_low: 8'hFF, gpio_high: 8'hFF,
                 timestamp: '0};
        send_item(item);
        item = '{command: bcef_pkg::CMD_POLL, gpio_low: 8'h00, gpio_high: 8'h00,
                 timestamp: {bcef_pkg::TIME_W{1'b1}}};
        send_item(item);
        item = '{command: bcef_pkg::CMD_POLL, gpio_low: 8'h00, gpio_high: 8'h00,
                 timestamp: '0};
        send_item(item);
        item = '{command: bcef_pkg::CMD_POLL, gpio_low: 8'h00, gpio_high: 8'hFF,
                 timestamp: bcef_pkg::TIME_W'(1)};
        send_item(item);
        item = '{command: bcef_pkg::CMD_READ, gpio_low: 8'h00, gpio_high: 8'h00,
                 timestamp: '0};
        send_item(item);
        send_read();
        send_read();
        stim_word = 6'h2F;
    endtask

    // Fill every usable slot, then drop, retry and recover.
    task automatic test_full_queue();
        for (int k = 1; k < DEPTH; k++)
            send_poll(bcef_pkg::BTN_W'(k));
        send_poll(6'h3F);
        send_poll(6'h3F);
        // Same as the last queued word: no change, so no drop either.
        send_poll(bcef_pkg::BTN_W'(DEPTH - 1));
        send_read();
        send_poll(6'h3F);
    endtask

    // Bursts of polls and reads with a changing mix, so the queue swings
    // between empty and full.
    task automatic test_random_traffic(input int count, input int idle_pct);
        int             poll_bias;
        int             burst_left;
        int             pick;
        bcef_pkg::cmd_t item;
        cmd_idle_pct = idle_pct;
        rsp_idle_pct = idle_pct;
        burst_left = 0;
        poll_bias  = 50;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(5, 40);
                poll_bias  = $urandom_range(10, 90);
            end
            burst_left--;
            if ($urandom_range(0, 99) < poll_bias)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_poll(stim_word);
                else if (pick < 45)
                begin
                    item.command   = bcef_pkg::CMD_POLL;
                    item.gpio_low  = 8'($urandom);
                    item.gpio_high = 8'($urandom);
                    item.timestamp = bcef_pkg::TIME_W'({$urandom, $urandom});
                    send_item(item);
                end
                else
                    send_poll(bcef_pkg::BTN_W'($urandom));
            end
            else
                send_read();
        end
    endtask

    // Stimulus sequence and end of run.
    initial
    begin
        int waited;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_full_queue();
        test_random_traffic(600, 38);
        test_random_traffic(300, 0);
        test_random_traffic(1000, 38);
        cmd_valid <= 1'b0;

        // Let the outstanding responses come back.
        waited = 0;
        while (pending_responses.size() != 0 && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            $error("%0d expected response items never arrived",
                   pending_responses.size());
            errors++;
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
